### hdl/dllcw_pkg.sv
// ----------------------------------------------------------------------------
// dllcw_pkg
// Shared types and constants for the linked-list DMA chain walker.
// ----------------------------------------------------------------------------
package dllcw_pkg;

  localparam int unsigned PtrW      = 24;
  localparam int unsigned FetchW    = 21;
  localparam int unsigned WordW     = 32;
  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 56;
  localparam int unsigned ApbAddrW  = 2;

  localparam logic [WordW-1:0] NodeLimitReset = 32'd2000000;
  localparam int unsigned      EndFlagBit     = 23;

  // Byte address of the node limit register.
  localparam logic [ApbAddrW-1:0] NodeLimitAddr = '0;

  localparam logic OP_START = 1'b0;
  localparam logic OP_NODE  = 1'b1;

  typedef enum logic [1:0] {
    REASON_WALKING = 2'd0,
    REASON_END     = 2'd1,
    REASON_LOOP    = 2'd2,
    REASON_LIMIT   = 2'd3
  } end_reason_t;

endpackage

### hdl/dllcw_apb_regs.sv
// ----------------------------------------------------------------------------
// dllcw_apb_regs
// APB register file holding the node limit of the chain walker.
// ----------------------------------------------------------------------------
module dllcw_apb_regs
  import dllcw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [WordW-1:0]    pwdata,
  output logic [WordW-1:0]    prdata,
  output logic                pready,
  output logic [WordW-1:0]    node_limit
);

  logic wr_en;

  // The node limit is the only register and sits at byte address zero.
  assign wr_en  = psel && penable && pwrite && (paddr == NodeLimitAddr);
  assign pready = 1'b1;
  assign prdata = node_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_limit <= NodeLimitReset;
    end else if (wr_en) begin
      node_limit <= pwdata;
    end
  end

endmodule

### hdl/dma_linked_list_chain_walker.sv
// ----------------------------------------------------------------------------
// dma_linked_list_chain_walker
// Follows a linked list of DMA command nodes and totals its length in words.
// ----------------------------------------------------------------------------
// A request passes through an input register, then a result register.
// Throughput: one request per cycle while the result stream is not stalled;
// the chain state is updated together with the result register.
// Reset (synchronous, active high) resets the walk state and both register
// stages, and sets node_limit to 2000000.
module dma_linked_list_chain_walker
  import dllcw_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 21
) (
  input  logic                clk,
  input  logic                rst,
  // Request stream.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,  // head_pointer[23:0], node_word[55:24]
  input  logic [0:0]          s_tuser,  // opcode[0]
  // Result stream.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,  // fetch_address[20:0], done_res[21],
                                        // chain_words[53:22], end_reason[55:54]
  // Configuration.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [WordW-1:0]    pwdata,
  output logic [WordW-1:0]    prdata,
  output logic                pready
);

  localparam logic [PtrW-1:0] AddrMask =
    PtrW'((25'(1) << ADDR_BITS) - 25'd1) & 24'hfffffc;

  logic [WordW-1:0] node_limit;

  // Input register.
  logic             in_v;
  logic             in_op;
  logic [PtrW-1:0]  in_head;
  logic [WordW-1:0] in_word;

  // Walk state.
  logic                 walking, walking_next;
  logic [WordW-1:0]     total_words, total_words_next;
  logic [WordW-1:0]     node_counter, node_counter_next;
  logic [ADDR_BITS-1:0] previous_address, previous_address_next;
  logic [ADDR_BITS-1:0] low_mark, low_mark_next;
  logic [ADDR_BITS-1:0] high_mark, high_mark_next;

  logic                 process;
  logic                 produce;
  logic                 is_start;
  logic [PtrW-1:0]      ptr;
  logic [PtrW-1:0]      masked;
  logic [ADDR_BITS-1:0] addr;
  logic [WordW:0]       sum;
  logic [WordW-1:0]     sat_total;
  logic [WordW-1:0]     cnt_before;
  logic [ADDR_BITS-1:0] prev_eff, low_eff, high_eff;
  end_reason_t          reason;
  logic                 done;
  logic [FetchW-1:0]    fetch;

  dllcw_apb_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .node_limit (node_limit)
  );

  assign process  = in_v && (!m_tvalid || m_tready);
  assign s_tready = !in_v || process;
  assign is_start = (in_op == OP_START);
  assign produce  = is_start || walking;

  always_comb begin
    sum       = {1'b0, total_words} + {25'd0, in_word[31:24]} + 33'd1;
    sat_total = sum[WordW] ? '1 : sum[WordW-1:0];
    ptr       = is_start ? in_head : in_word[PtrW-1:0];
    masked    = ptr & AddrMask;
    addr      = masked[ADDR_BITS-1:0];
    // A start request begins from a cleared detector and counter.
    cnt_before = is_start ? '0 : node_counter;
    prev_eff   = is_start ? '1 : previous_address;
    low_eff    = is_start ? '1 : low_mark;
    high_eff   = is_start ? '1 : high_mark;

    walking_next          = walking;
    total_words_next      = is_start ? 32'd1 : sat_total;
    node_counter_next     = cnt_before + 32'd1;
    previous_address_next = prev_eff;
    low_mark_next         = low_eff;
    high_mark_next        = high_eff;
    reason                = REASON_WALKING;

    if (!is_start && ptr[EndFlagBit]) begin
      reason            = REASON_END;
      node_counter_next = node_counter;
    end else if (cnt_before > node_limit) begin
      reason = REASON_LIMIT;
    end else if (addr == low_eff || addr == high_eff) begin
      reason = REASON_LOOP;
    end else begin
      if (addr < prev_eff) begin
        low_mark_next = addr;
      end else begin
        high_mark_next = addr;
      end
      previous_address_next = addr;
    end

    walking_next = (reason == REASON_WALKING);
    done         = (reason != REASON_WALKING);
    fetch        = done ? '0 : masked[FetchW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v             <= 1'b0;
      m_tvalid         <= 1'b0;
      walking          <= 1'b0;
      total_words      <= '0;
      node_counter     <= '0;
      previous_address <= '1;
      low_mark         <= '1;
      high_mark        <= '1;
    end else begin
      if (s_tvalid && s_tready) begin
        in_v <= 1'b1;
      end else if (process) begin
        in_v <= 1'b0;
      end

      if (process) begin
        m_tvalid <= produce;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // Node headers that arrive while idle are dropped without a trace.
      if (process && produce) begin
        walking          <= walking_next;
        total_words      <= total_words_next;
        node_counter     <= node_counter_next;
        previous_address <= previous_address_next;
        low_mark         <= low_mark_next;
        high_mark        <= high_mark_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser[0];
      in_head <= s_tdata[PtrW-1:0];
      in_word <= s_tdata[PtrW +: WordW];
    end
    if (process && produce) begin
      m_tdata <= {reason, total_words_next, done, fetch};
    end
  end

endmodule
